>>> sv/stdisp_pkg.sv
// shared task dispatcher package: widths, register map, status codes,
// item and control structs, eligibility function
// no dependencies
package stdisp_pkg;

    localparam int MAX_TASKS = 64;
    localparam int TASK_W    = $clog2(MAX_TASKS);
    localparam int COUNT_W   = 7;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;

    // register indexes, one per 8-byte slot
    localparam logic [1:0] REG_TASK_COUNT    = 2'd0;
    localparam logic [1:0] REG_FIRST_PARTIAL = 2'd1;
    localparam logic [1:0] REG_EXCL_ENABLE   = 2'd2;
    localparam logic [1:0] REG_VALID_MASK    = 2'd3;

    // pointer status codes
    localparam logic [1:0] ST_RESTART   = 2'd0;
    localparam logic [1:0] ST_POINTER   = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [TASK_W-1:0] prev_task;
        logic              prev_valid;
    } req_item_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_res;
        logic              granted;
    } rsp_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   task_count;
        logic [COUNT_W-1:0]   first_partial;
        logic                 exclusion_enable;
        logic [MAX_TASKS-1:0] valid_mask;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic search;
        logic scan;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_cmd;
        logic exhausted;
        logic hit;
        logic elig;
        logic idx_last;
        logic step_last;
        logic out_busy;
    } dp_stat_t;

    // task is eligible when below the task count and not excluded
    function automatic logic is_eligible(input logic [TASK_W-1:0] idx, input cfg_t cfg);
        logic below;
        below = ({1'b0, idx} < cfg.task_count);
        return below && (!cfg.exclusion_enable || cfg.valid_mask[idx]);
    endfunction

endpackage

>>> sv/stdisp_cfg.sv
// configuration register file with apb-style access
// depends on stdisp_pkg
module stdisp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stdisp_pkg::ADDR_W-1:0] paddr,
    input  logic [stdisp_pkg::DATA_W-1:0] pwdata,
    output logic [stdisp_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    output stdisp_pkg::cfg_t              cfg
);
    import stdisp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.task_count       <= '0;
            cfg_reg.first_partial    <= '0;
            cfg_reg.exclusion_enable <= 1'b0;
            cfg_reg.valid_mask       <= '1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TASK_COUNT:    cfg_reg.task_count       <= pwdata[COUNT_W-1:0];
                REG_FIRST_PARTIAL: cfg_reg.first_partial    <= pwdata[COUNT_W-1:0];
                REG_EXCL_ENABLE:   cfg_reg.exclusion_enable <= pwdata[0];
                REG_VALID_MASK:    cfg_reg.valid_mask       <= pwdata[MAX_TASKS-1:0];
                default:           ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_TASK_COUNT:    prdata[COUNT_W-1:0]   = cfg_reg.task_count;
            REG_FIRST_PARTIAL: prdata[COUNT_W-1:0]   = cfg_reg.first_partial;
            REG_EXCL_ENABLE:   prdata[0]             = cfg_reg.exclusion_enable;
            REG_VALID_MASK:    prdata[MAX_TASKS-1:0] = cfg_reg.valid_mask;
            default:           prdata = '0;
        endcase
    end

endmodule

>>> sv/stdisp_dp.sv
// dispatcher datapath: finished flags, shared pointer, scan index,
// working result and output register
// depends on stdisp_pkg
module stdisp_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stdisp_pkg::cfg_t      cfg,
    input  stdisp_pkg::req_item_t req,
    input  stdisp_pkg::dp_cmd_t   cmd,
    output stdisp_pkg::dp_stat_t  stat,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output stdisp_pkg::rsp_item_t rsp
);
    import stdisp_pkg::*;

    logic [MAX_TASKS-1:0] flags_reg, flags_next;
    logic [TASK_W-1:0]    next_idx_reg, next_idx_next;
    logic [1:0]           status_reg, status_next;
    logic [TASK_W-1:0]    idx_reg, idx_next;
    logic [TASK_W-1:0]    step_reg, step_next;
    rsp_item_t            res_reg, res_next;
    rsp_item_t            out_reg;
    logic                 out_valid_reg, out_valid_next;

    logic                 elig_idx;
    logic                 hit;
    logic                 ptr_ok;
    logic [TASK_W-1:0]    start_idx;

    // eligibility of the scan index and of the saved pointer
    assign elig_idx  = is_eligible(idx_reg, cfg);
    assign hit       = elig_idx && !flags_reg[idx_reg];
    assign ptr_ok    = (status_reg == ST_POINTER) && is_eligible(next_idx_reg, cfg);
    assign start_idx = ptr_ok ? next_idx_reg : '0;

    // status toward the controller
    assign stat.req_cmd   = req.cmd;
    assign stat.exhausted = status_reg[1];
    assign stat.hit       = hit;
    assign stat.elig      = elig_idx;
    assign stat.idx_last  = (idx_reg == TASK_W'(MAX_TASKS - 1));
    assign stat.step_last = (step_reg == TASK_W'(MAX_TASKS - 1));
    assign stat.out_busy  = out_valid_reg && !rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // next-state logic for flags, pointer and scan
    always_comb
    begin
        flags_next    = flags_reg;
        next_idx_next = next_idx_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        res_next      = res_reg;
        if (cmd.start)
        begin
            res_next = '0;
            if (req.cmd)
            begin
                flags_next    = '0;
                next_idx_next = '0;
                status_next   = ST_RESTART;
            end
            else
            begin
                if (req.prev_valid)
                    flags_next[req.prev_task] = 1'b1;
                idx_next  = start_idx;
                step_next = '0;
            end
        end
        else if (cmd.search)
        begin
            if (hit)
            begin
                res_next.task_res = idx_reg;
                res_next.granted  = 1'b1;
                if ({1'b0, idx_reg} < cfg.first_partial)
                    flags_next[idx_reg] = 1'b1;
                if (stat.idx_last)
                    status_next = ST_RESTART;
                else
                    idx_next = idx_reg + 1'b1;
            end
            else if (stat.step_last)
                status_next = ST_EXHAUSTED;
            else
            begin
                idx_next  = idx_reg + 1'b1;
                step_next = step_reg + 1'b1;
            end
        end
        else if (cmd.scan)
        begin
            // look for the next eligible task above the granted one
            if (elig_idx)
            begin
                next_idx_next = idx_reg;
                status_next   = ST_POINTER;
            end
            else if (stat.idx_last)
                status_next = ST_RESTART;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            next_idx_reg  <= '0;
            status_reg    <= ST_RESTART;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg     <= flags_next;
            next_idx_reg  <= next_idx_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        step_reg <= step_next;
        res_reg  <= res_next;
        if (cmd.load_out)
            out_reg <= res_reg;
    end

    // unused status code never appears
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg != 2'd3)
        else $error("pointer status holds unused code");

    // a non-shareable grant is marked finished right away
    a_partial_mark: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search && hit && ({1'b0, idx_reg} < cfg.first_partial)
        |=> flags_reg[$past(idx_reg)])
        else $error("partial task not marked finished after grant");

    // restart clears every finished flag and the pointer
    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && req.cmd |=> (flags_reg == '0) && (status_reg == ST_RESTART))
        else $error("restart left flags or pointer set");

    // a result without grant carries task zero
    a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.granted |-> out_reg.task_res == '0)
        else $error("ungranted item carries nonzero task");

endmodule

>>> sv/stdisp_ctrl.sv
// dispatcher controller: sequences accept, circular search, pointer scan
// and result hand-off
// depends on stdisp_pkg
module stdisp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  stdisp_pkg::dp_stat_t stat,
    output stdisp_pkg::dp_cmd_t  cmd
);
    import stdisp_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg, state_next;

    assign req_ready    = (state_reg == S_IDLE);
    assign cmd.start    = req_ready && req_valid;
    assign cmd.search   = (state_reg == S_SEARCH);
    assign cmd.scan     = (state_reg == S_SCAN);
    assign cmd.load_out = (state_reg == S_RESULT) && !stat.out_busy;

    // state transitions
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (stat.req_cmd || stat.exhausted)
                        state_next = S_RESULT;
                    else
                        state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.hit)
                    state_next = stat.idx_last ? S_RESULT : S_SCAN;
                else if (stat.step_last)
                    state_next = S_RESULT;
            end
            S_SCAN:
            begin
                if (stat.elig || stat.idx_last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!stat.out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // restart and exhausted items skip the search entirely
    a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && (stat.req_cmd || stat.exhausted) |=> state_reg == S_RESULT)
        else $error("restart or exhausted item entered search");

endmodule

>>> sv/shared_task_dispatcher_unit.sv
// Shared task dispatcher top level: config registers, controller, datapath.
// Restart and exhausted items go straight to the result; other items run the
// circular search, one task per cycle, then the forward scan for the next
// pointer (skipped when the search ends without a grant or on the last task).
// One item at a time; a new item is taken while the last result waits.
// Reset (rst_n low, async): finished flags and pointer cleared, registers to defaults.
module shared_task_dispatcher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  stdisp_pkg::req_item_t         req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output stdisp_pkg::rsp_item_t         rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stdisp_pkg::ADDR_W-1:0] paddr,
    input  logic [stdisp_pkg::DATA_W-1:0] pwdata,
    output logic [stdisp_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);
    import stdisp_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // configuration registers
    stdisp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencing
    stdisp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // flags, pointer and result path
    stdisp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> sim/testbench.sv
// testbench for shared_task_dispatcher_unit: directed and random request streams,
// an in-line dispatch predictor, and field-by-field checking of every grant
// depends on stdisp_pkg and the dispatcher top level
module testbench;
    import stdisp_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_item_t           req = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_item_t           rsp;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // requests waiting to be offered, grants waiting to come back
    req_item_t req_backlog[$];
    rsp_item_t pending_grants[$];
    int        err_count = 0;

    // shadow of the dispatcher registers and scan state
    cfg_t             sh_cfg = {7'd0, 7'd0, 1'b0, {MAX_TASKS{1'b1}}};
    logic [63:0]      sh_finished = '0;
    logic [TASK_W-1:0] sh_ptr = '0;
    logic [1:0]       sh_status = ST_RESTART;

    // sender and receiver pacing
    int burst_left = 0;
    int gap_left = 0;
    int rsp_taken = 0;
    int hold_cnt = 0;
    int mode = 0;
    int mode_left = 0;

    shared_task_dispatcher_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // task can be handed out under the current registers
    function automatic bit task_eligible(input int i);
        int lim;
        lim = (sh_cfg.task_count > MAX_TASKS) ? MAX_TASKS : sh_cfg.task_count;
        if (i >= lim)
            return 1'b0;
        if (sh_cfg.exclusion_enable)
            return sh_cfg.valid_mask[i];
        return 1'b1;
    endfunction

    // lowest eligible task at or above from, MAX_TASKS when none
    function automatic int first_eligible_from(input int from);
        for (int i = from; i < MAX_TASKS; i++)
            if (task_eligible(i))
                return i;
        return MAX_TASKS;
    endfunction

    // expected grant for one request, advancing the shadow state
    task automatic predict_dispatch(input req_item_t r, output rsp_item_t g);
        int start;
        int idx;
        int nxt;
        g = '0;
        if (r.cmd)
        begin
            sh_finished = '0;
            sh_ptr = '0;
            sh_status = ST_RESTART;
            return;
        end
        if (r.prev_valid)
            sh_finished[r.prev_task] = 1'b1;
        if (sh_status != ST_RESTART && sh_status != ST_POINTER)
            return;
        if (sh_status == ST_POINTER && task_eligible(sh_ptr))
            start = sh_ptr;
        else
            start = first_eligible_from(0);
        if (start >= MAX_TASKS)
        begin
            sh_status = ST_EXHAUSTED;
            return;
        end
        // circular walk skipping finished tasks
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            idx = (start + k) % MAX_TASKS;
            if (task_eligible(idx) && !sh_finished[idx])
            begin
                if (idx < sh_cfg.first_partial)
                    sh_finished[idx] = 1'b1;
                nxt = first_eligible_from(idx + 1);
                if (nxt < MAX_TASKS)
                begin
                    sh_ptr = nxt[TASK_W-1:0];
                    sh_status = ST_POINTER;
                end
                else
                    sh_status = ST_RESTART;
                g.task_res = idx[TASK_W-1:0];
                g.granted = 1'b1;
                return;
            end
        end
        sh_status = ST_EXHAUSTED;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic add_req(input logic cmd, input int ptask, input logic pvalid);
        req_item_t r;
        r.cmd = cmd;
        r.prev_task = ptask[TASK_W-1:0];
        r.prev_valid = pvalid;
        req_backlog.push_back(r);
    endtask

    // register write: setup cycle then access cycle
    task automatic apb_write(input logic [1:0] ridx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {ridx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (ridx)
            REG_TASK_COUNT:    sh_cfg.task_count = value[COUNT_W-1:0];
            REG_FIRST_PARTIAL: sh_cfg.first_partial = value[COUNT_W-1:0];
            REG_EXCL_ENABLE:   sh_cfg.exclusion_enable = value[0];
            REG_VALID_MASK:    sh_cfg.valid_mask = value;
            default: ;
        endcase
    endtask

    // block until every queued item is accepted and every grant returned
    task automatic wait_idle();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || req_valid || pending_grants.size() != 0);
    endtask

    // sender: bursts of items with random gaps, predicts at acceptance
    always @(posedge clk)
    begin : sender
        rsp_item_t g;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                predict_dispatch(req, g);
                pending_grants.push_back(g);
            end
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    req <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 5);
                            8:          gap_left = $urandom_range(6, 20);
                            default:    gap_left = $urandom_range(20, 80);
                        endcase
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern in stretches, plus a long hold-off now and then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                rsp_taken++;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_ready <= 1'b0;
            end
            else if (rsp_valid && rsp_ready && (rsp_taken % 150 == 149))
            begin
                hold_cnt = 300;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 60);
                end
                else
                    mode_left--;
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= $urandom_range(0, 1);
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor: compare each grant with the oldest prediction
    always @(posedge clk)
    begin : monitor
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_grants.size() == 0)
                report_mismatch($sformatf("unexpected item task_res=%0d granted=%0b",
                                          rsp.task_res, rsp.granted));
            else
            begin
                want = pending_grants.pop_front();
                if (rsp.granted !== want.granted)
                    report_mismatch($sformatf("granted %0b, want %0b",
                                              rsp.granted, want.granted));
                if (rsp.task_res !== want.task_res)
                    report_mismatch($sformatf("task_res %0d, want %0d",
                                              rsp.task_res, want.task_res));
            end
        end
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int lim;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: no tasks, completion while exhausted, restart
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 63, 1'b1);
        add_req(1'b1, 5, 1'b1);
        wait_idle();

        // all tasks shareable
        apb_write(REG_TASK_COUNT, 64'd64);
        apb_write(REG_FIRST_PARTIAL, 64'd0);
        apb_write(REG_EXCL_ENABLE, 64'd0);
        apb_write(REG_VALID_MASK, '1);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 0, 1'b1);
        add_req(1'b0, 62, 1'b1);
        wait_idle();

        // count above max, all non-shareable, only ends of the mask: stale pointer
        apb_write(REG_TASK_COUNT, 64'd127);
        apb_write(REG_FIRST_PARTIAL, 64'd127);
        apb_write(REG_EXCL_ENABLE, 64'd1);
        apb_write(REG_VALID_MASK, 64'h8000_0000_0000_0001);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 10, 1'b1);
        add_req(1'b1, 63, 1'b0);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 0, 1'b0);
        wait_idle();

        // nothing eligible
        apb_write(REG_VALID_MASK, 64'd0);
        add_req(1'b1, 0, 1'b0);
        add_req(1'b0, 3, 1'b1);
        wait_idle();

        // odd tasks only, partial threshold mid-range, wraparound skip
        apb_write(REG_VALID_MASK, 64'hAAAA_AAAA_AAAA_AAAA);
        apb_write(REG_TASK_COUNT, 64'd10);
        apb_write(REG_FIRST_PARTIAL, 64'd4);
        add_req(1'b1, 0, 1'b0);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 1, 1'b1);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 5, 1'b1);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 0, 1'b0);
        wait_idle();

        // shrink the count under the pointer
        apb_write(REG_TASK_COUNT, 64'd6);
        add_req(1'b0, 0, 1'b0);
        add_req(1'b0, 63, 1'b1);
        wait_idle();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 12; ph++)
        begin
            if ($urandom_range(0, 9) < 7)
                case ($urandom_range(0, 9))
                    0:          apb_write(REG_TASK_COUNT, 64'd0);
                    1:          apb_write(REG_TASK_COUNT, 64'd1);
                    2:          apb_write(REG_TASK_COUNT, 64'd64);
                    3:          apb_write(REG_TASK_COUNT, $urandom_range(65, 127));
                    4, 5, 6:    apb_write(REG_TASK_COUNT, $urandom_range(2, 12));
                    default:    apb_write(REG_TASK_COUNT, $urandom_range(1, 64));
                endcase
            if ($urandom_range(0, 9) < 7)
                case ($urandom_range(0, 5))
                    0:          apb_write(REG_FIRST_PARTIAL, 64'd0);
                    1:          apb_write(REG_FIRST_PARTIAL, 64'd127);
                    2:          apb_write(REG_FIRST_PARTIAL, 64'd64);
                    default:    apb_write(REG_FIRST_PARTIAL, $urandom_range(0, 64));
                endcase
            if ($urandom_range(0, 9) < 7)
                apb_write(REG_EXCL_ENABLE, $urandom_range(0, 1));
            if ($urandom_range(0, 9) < 7)
                case ($urandom_range(0, 5))
                    0:          apb_write(REG_VALID_MASK, '1);
                    1:          apb_write(REG_VALID_MASK, 64'd0);
                    2:          apb_write(REG_VALID_MASK, 64'd1 << $urandom_range(0, 63));
                    default:    apb_write(REG_VALID_MASK, {$urandom, $urandom});
                endcase

            // workers mostly report tasks in range; some restarts and stray reports
            lim = (sh_cfg.task_count > MAX_TASKS) ? MAX_TASKS : sh_cfg.task_count;
            if ($urandom_range(0, 1))
                add_req(1'b1, $urandom_range(0, 63), $urandom_range(0, 1));
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(0, 99) < 6)
                    add_req(1'b1, $urandom_range(0, 63), $urandom_range(0, 1));
                else if (lim > 0 && $urandom_range(0, 4) != 0)
                    add_req(1'b0, $urandom_range(0, lim - 1), $urandom_range(0, 9) < 7);
                else
                    add_req(1'b0, $urandom_range(0, 63), $urandom_range(0, 1));
            end
            wait_idle();
        end

        // let any stray item show up
        repeat (150) @(posedge clk);
        if (pending_grants.size() != 0)
            report_mismatch($sformatf("%0d grants never returned", pending_grants.size()));
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
sv/stdisp_pkg.sv
sv/stdisp_cfg.sv
sv/stdisp_dp.sv
sv/stdisp_ctrl.sv
sv/shared_task_dispatcher_unit.sv
sim/testbench.sv
